FILE: sv/sector_cache_second_chance_unit_defines.svh
// Assertion macros shared by the sector cache second chance unit RTL.
`ifndef SECTOR_CACHE_SECOND_CHANCE_UNIT_DEFINES_SVH
`define SECTOR_CACHE_SECOND_CHANCE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SCSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCSC_ASSERT_IMP(lbl, ante, cons, msg)
`define SCSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/scsc_pkg.sv
// Types, constants and action codes of the sector cache second chance unit.
`timescale 1ns / 1ps
`default_nettype none

package scsc_pkg;

    localparam int ENTRIES     = 64;
    localparam int SLOT_W      = $clog2(ENTRIES);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int SECTOR_W    = 32;
    localparam int SECTOR_BITS = 32;
    localparam logic [SECTOR_W-1:0] SECTOR_MASK =
        SECTOR_W'((64'(1) << SECTOR_BITS) - 64'(1));

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]          action;
        logic [SECTOR_W-1:0] sector;
    } req_word_t;

    typedef struct packed {
        logic [5:0]          slot;
        logic                hit;
        logic                fill_needed;
        logic                writeback_needed;
        logic [SECTOR_W-1:0] writeback_sector;
        logic                last;
    } res_word_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit_hit;
        logic commit_fill;
        logic evict_step;
        logic commit_evict;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic full;
        logic ref_at_hand;
    } sts_t;

endpackage

`default_nettype wire

FILE: sv/scsc_datapath.sv
// Tag RAM, dirty and reference bits, clock hand and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "sector_cache_second_chance_unit_defines.svh"

module scsc_datapath import scsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_word_t request,
    input  wire cmd_t      cmd,
    output sts_t           sts,
    output logic           result_valid,
    output res_word_t      result
);

    logic [SECTOR_W-1:0] tag_mem [ENTRIES];

    logic [1:0]          act_reg, act_next;
    logic [SECTOR_W-1:0] sec_reg, sec_next;
    logic [SECTOR_W-1:0] tag_q_reg;
    logic [CNT_W-1:0]    addr_reg, addr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    filled_reg, filled_next;
    logic [SLOT_W-1:0]   hand_reg, hand_next;
    logic [SLOT_W-1:0]   victim_reg, victim_next;
    logic [ENTRIES-1:0]  dirty_reg, dirty_next;
    logic [ENTRIES-1:0]  ref_reg, ref_next;
    res_word_t           res_reg, res_next;
    logic                res_vld_reg, res_vld_next;

    logic                mem_we, mem_re;
    logic [SLOT_W-1:0]   mem_waddr, mem_raddr;
    logic                is_flush, is_write;
    logic [ENTRIES:0]    above;
    logic [SLOT_W-1:0]   new_slot;

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] v);
        wrap_inc = (v == SLOT_W'(ENTRIES - 1)) ? '0 : v + 1'b1;
    endfunction

    assign is_flush = (act_reg == ACT_FLUSH);
    assign is_write = (act_reg == ACT_WRITE);
    assign above    = {(ENTRIES + 1){1'b1}} << ({1'b0, rd_idx_reg} + CNT_W'(1));
    assign new_slot = filled_reg[SLOT_W-1:0];

    assign sts.hit         = rd_vld_reg && (tag_q_reg == sec_reg);
    assign sts.scan_done   = (addr_reg >= filled_reg) && !rd_vld_reg;
    assign sts.full        = (filled_reg == CNT_W'(ENTRIES));
    assign sts.ref_at_hand = ref_reg[hand_reg];

    always_comb
    begin
        act_next     = act_reg;
        sec_next     = sec_reg;
        addr_next    = addr_reg;
        rd_vld_next  = rd_vld_reg;
        rd_idx_next  = rd_idx_reg;
        filled_next  = filled_reg;
        hand_next    = hand_reg;
        victim_next  = victim_reg;
        dirty_next   = dirty_reg;
        ref_next     = ref_reg;
        res_next     = '0;
        res_vld_next = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = new_slot;
        mem_raddr    = addr_reg[SLOT_W-1:0];

        if (cmd.load)
        begin
            act_next    = request.action;
            sec_next    = request.sector & SECTOR_MASK;
            addr_next   = '0;
            rd_vld_next = 1'b0;
        end

        if (cmd.scan)
        begin
            rd_vld_next = 1'b0;
            if (addr_reg < filled_reg)
            begin
                if (!is_flush || dirty_reg[addr_reg[SLOT_W-1:0]])
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = addr_reg[SLOT_W-1:0];
                end
                addr_next = addr_reg + 1'b1;
            end
            if (is_flush && rd_vld_reg)
            begin
                res_vld_next              = 1'b1;
                res_next.slot             = 6'(rd_idx_reg);
                res_next.writeback_needed = 1'b1;
                res_next.writeback_sector = tag_q_reg;
                res_next.last             = ((dirty_reg & above[ENTRIES-1:0]) == '0);
            end
        end

        if (cmd.commit_hit)
        begin
            ref_next[rd_idx_reg] = 1'b1;
            if (is_write)
                dirty_next[rd_idx_reg] = 1'b1;
            res_vld_next  = 1'b1;
            res_next.slot = 6'(rd_idx_reg);
            res_next.hit  = 1'b1;
            res_next.last = 1'b1;
        end

        if (cmd.commit_fill)
        begin
            mem_we               = 1'b1;
            mem_waddr            = new_slot;
            filled_next          = filled_reg + 1'b1;
            ref_next[new_slot]   = 1'b1;
            dirty_next[new_slot] = is_write;
            res_vld_next         = 1'b1;
            res_next.slot        = 6'(new_slot);
            res_next.fill_needed = 1'b1;
            res_next.last        = 1'b1;
        end

        if (cmd.evict_step)
        begin
            if (ref_reg[hand_reg])
            begin
                ref_next[hand_reg] = 1'b0;
                hand_next          = wrap_inc(hand_reg);
            end
            else
            begin
                victim_next = hand_reg;
                mem_re      = 1'b1;
                mem_raddr   = hand_reg;
            end
        end

        if (cmd.commit_evict)
        begin
            mem_we                 = 1'b1;
            mem_waddr              = victim_reg;
            dirty_next[victim_reg] = is_write;
            ref_next[victim_reg]   = 1'b1;
            hand_next              = wrap_inc(victim_reg);
            res_vld_next           = 1'b1;
            res_next.slot          = 6'(victim_reg);
            res_next.fill_needed   = 1'b1;
            res_next.last          = 1'b1;
            if (dirty_reg[victim_reg])
            begin
                res_next.writeback_needed = 1'b1;
                res_next.writeback_sector = tag_q_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tag_mem[mem_waddr] <= sec_reg;
        if (mem_re)
            tag_q_reg <= tag_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            filled_reg  <= '0;
            hand_reg    <= '0;
            dirty_reg   <= '0;
            ref_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            addr_reg    <= addr_next;
            rd_vld_reg  <= rd_vld_next;
            filled_reg  <= filled_next;
            hand_reg    <= hand_next;
            dirty_reg   <= dirty_next;
            ref_reg     <= ref_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        sec_reg    <= sec_next;
        rd_idx_reg <= rd_idx_next;
        victim_reg <= victim_next;
        res_reg    <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    // hand only moves once every slot is in use
    `SCSC_ASSERT_IMP(a_hand_idle, filled_reg != CNT_W'(ENTRIES), hand_reg == '0, "hand moved while filling")
    `SCSC_ASSERT_IMP(a_hit_clean, res_vld_reg && res_reg.hit, !res_reg.fill_needed && !res_reg.writeback_needed, "hit with fill or writeback")
    `SCSC_ASSERT_NEXT(a_fill_grow, cmd.commit_fill, filled_reg == $past(filled_reg) + 1'b1, "fill count did not advance")

endmodule

`default_nettype wire

FILE: sv/scsc_ctrl.sv
// Control state machine sequencing lookup, eviction and flush.
`timescale 1ns / 1ps
`default_nettype none

module scsc_ctrl import scsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] action,
    input  wire sts_t       sts,
    output cmd_t            cmd,
    output logic            busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EVICT,
        S_VICTIM,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (action)
                        ACT_READ, ACT_WRITE: state_next = S_LOOK;
                        ACT_FLUSH:           state_next = S_FLUSH;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOK:
            begin
                if (sts.hit)
                begin
                    cmd.commit_hit = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (sts.scan_done)
                begin
                    if (sts.full)
                        state_next = S_EVICT;
                    else
                    begin
                        cmd.commit_fill = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                    cmd.scan = 1'b1;
            end
            S_EVICT:
            begin
                cmd.evict_step = 1'b1;
                if (!sts.ref_at_hand)
                    state_next = S_VICTIM;
            end
            S_VICTIM:
            begin
                cmd.commit_evict = 1'b1;
                state_next       = S_IDLE;
            end
            S_FLUSH:
            begin
                if (sts.scan_done)
                    state_next = S_IDLE;
                else
                    cmd.scan = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: sv/sector_cache_second_chance_unit.sv
// Top level of the second chance sector cache tag and replacement unit.
//
//  channel   | handshake             | word
//  ----------+-----------------------+------------------------------------
//  request   | start && !busy        | action, sector
//  result    | result_valid (strobe) | slot, hit, fill_needed,
//            |                       | writeback_needed, writeback_sector, last
//
// Tags sit in a single-port RAM scanned one slot per cycle. A read or write
// stops its scan on a hit; on a miss it fills the next free slot or, with
// all slots in use, evicts. Eviction clears the mark of each referenced slot
// the hand passes and takes the first unreferenced one. A flush holds busy
// while it scans the filled slots and strobes one word per dirty slot. Reset clears the
// marks, hand and fill count at once; no clearing pass. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module sector_cache_second_chance_unit import scsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire req_word_t request,
    output logic           result_valid,
    output res_word_t      result
);

    cmd_t cmd;
    sts_t sts;

    scsc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    scsc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
